[rtl/wdf_pkg.sv]
package wdf_pkg;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_PING  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // opcodes
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'ha;

    // length codes in the second header byte
    localparam logic [6:0] LEN_EXT16 = 7'h7e;
    localparam logic [6:0] LEN_EXT64 = 7'h7f;

    // extended length and key byte counts, minus one
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    // default depth of the queue between parser and output stage
    localparam int QUEUE_DEPTH_DEF = 4;

    // parser phases
    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_PAY  = 5'b10000
    } phase_t;

    // one classified result on its way to the output stage
    typedef struct packed {
        logic [7:0] raw_byte;
        logic [7:0] key_byte;
        logic       data_valid;
        logic [1:0] kind;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
    } cmd_t;

    // classify an opcode
    function automatic logic [1:0] kind_of(input logic [3:0] op);
        logic [1:0] k;
        if (op <= OP_BINARY || op == OP_PONG)
            k = KIND_DATA;
        else if (op == OP_PING)
            k = KIND_PING;
        else if (op == OP_CLOSE)
            k = KIND_CLOSE;
        else
            k = KIND_ERROR;
        return k;
    endfunction

endpackage

[rtl/wdf_front.sv]
module wdf_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     rx_byte,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           queue_full,
    output logic           push,
    output wdf_pkg::cmd_t  push_cmd
);
    import wdf_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  count_reg, count_next;
    logic [63:0] remain_reg, remain_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  keypos_reg, keypos_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;

    logic        accept;
    logic [63:0] ext_shift;
    logic [63:0] hdr_len;
    logic        hdr_end;
    logic [7:0]  key_sel;
    logic [1:0]  kind;
    logic        pay_last;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign kind     = kind_of(opcode_reg);
    assign ext_shift = {remain_reg[55:0], rx_byte};
    assign pay_last = (remain_reg == 64'd1);

    // key byte for the current payload position
    always_comb
    begin
        case (keypos_reg)
            2'd0:    key_sel = key_reg[31:24];
            2'd1:    key_sel = key_reg[23:16];
            2'd2:    key_sel = key_reg[15:8];
            default: key_sel = key_reg[7:0];
        endcase
    end

    // header and payload parsing
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        key_next    = key_reg;
        keypos_next = keypos_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        hdr_end     = 1'b0;
        hdr_len     = remain_reg;
        push        = 1'b0;
        push_cmd    = '{raw_byte: 8'd0, key_byte: 8'd0, data_valid: 1'b0, kind: kind,
                        opcode: opcode_reg, fin: fin_reg, last: 1'b1};
        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    masked_next = rx_byte[7];
                    key_next    = 32'd0;
                    remain_next = 64'd0;
                    if (rx_byte[6:0] == LEN_EXT16)
                    begin
                        count_next = EXT16_LAST;
                        phase_next = PH_EXT;
                    end
                    else if (rx_byte[6:0] == LEN_EXT64)
                    begin
                        count_next = EXT64_LAST;
                        phase_next = PH_EXT;
                    end
                    else
                    begin
                        remain_next = {57'd0, rx_byte[6:0]};
                        if (rx_byte[7])
                        begin
                            count_next = KEY_LAST;
                            phase_next = PH_KEY;
                        end
                        else
                        begin
                            hdr_end = 1'b1;
                            hdr_len = {57'd0, rx_byte[6:0]};
                        end
                    end
                end
                PH_EXT:
                begin
                    remain_next = ext_shift;
                    if (count_reg != 3'd0)
                        count_next = count_reg - 3'd1;
                    else if (masked_reg)
                    begin
                        count_next = KEY_LAST;
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        hdr_end = 1'b1;
                        hdr_len = ext_shift;
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    if (count_reg != 3'd0)
                        count_next = count_reg - 3'd1;
                    else
                        hdr_end = 1'b1;
                end
                PH_PAY:
                begin
                    keypos_next = keypos_reg + 2'd1;
                    remain_next = remain_reg - 64'd1;
                    if (pay_last)
                        phase_next = PH_HDR0;
                    push_cmd.raw_byte   = rx_byte;
                    push_cmd.key_byte   = masked_reg ? key_sel : 8'd0;
                    push_cmd.data_valid = 1'b1;
                    push_cmd.last       = pay_last;
                    if (opcode_reg == OP_PONG)
                        push = 1'b0;
                    else if (kind[1])
                    begin
                        push                = pay_last;
                        push_cmd.raw_byte   = 8'd0;
                        push_cmd.key_byte   = 8'd0;
                        push_cmd.data_valid = 1'b0;
                    end
                    else
                        push = 1'b1;
                end
                default:
                begin
                    fin_next    = rx_byte[7];
                    opcode_next = rx_byte[3:0];
                    count_next  = 3'd0;
                    phase_next  = PH_HDR1;
                end
            endcase

            // header complete: start payload or close an empty frame
            if (hdr_end)
            begin
                keypos_next = 2'd0;
                if (hdr_len == 64'd0)
                begin
                    phase_next = PH_HDR0;
                    push       = 1'b1;
                end
                else
                    phase_next = PH_PAY;
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            count_reg  <= 3'd0;
            remain_reg <= 64'd0;
            key_reg    <= 32'd0;
            keypos_reg <= 2'd0;
            fin_reg    <= 1'b0;
            opcode_reg <= 4'd0;
            masked_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            key_reg    <= key_next;
            keypos_reg <= keypos_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
        end
    end

endmodule

[rtl/wdf_queue.sv]
module wdf_queue #(
    parameter int DEPTH = wdf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wdf_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output wdf_pkg::cmd_t  pop_cmd,
    output logic           empty
);
    import wdf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == CW'(0));
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

[rtl/wdf_back.sv]
module wdf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  wdf_pkg::cmd_t  pop_cmd,
    output logic           pop,
    output logic [7:0]     data_byte,
    output logic           data_valid,
    output logic [1:0]     frame_kind,
    output logic [3:0]     frame_opcode,
    output logic           final_fragment,
    output logic           last_of_frame,
    output logic           closing,
    output logic           out_valid,
    input  logic           out_stall
);
    import wdf_pkg::*;

    logic       valid_reg, valid_next;
    logic       closing_reg, closing_next;
    logic [7:0] data_reg;
    logic       dvalid_reg;
    logic [1:0] kind_reg;
    logic [3:0] opcode_reg;
    logic       fin_reg;
    logic       last_reg;
    logic       load;

    assign load = !empty && (!valid_reg || !out_stall);
    assign pop  = load;

    // output valid and sticky closing flag
    always_comb
    begin
        valid_next   = valid_reg;
        closing_next = closing_reg;
        if (load)
        begin
            valid_next = 1'b1;
            if (pop_cmd.last && pop_cmd.kind[1])
                closing_next = 1'b1;
        end
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            closing_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            closing_reg <= closing_next;
        end
    end

    // result register, unmasking on load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg   <= pop_cmd.raw_byte ^ pop_cmd.key_byte;
            dvalid_reg <= pop_cmd.data_valid;
            kind_reg   <= pop_cmd.kind;
            opcode_reg <= pop_cmd.opcode;
            fin_reg    <= pop_cmd.fin;
            last_reg   <= pop_cmd.last;
        end
    end

    assign out_valid      = valid_reg;
    assign data_byte      = data_reg;
    assign data_valid     = dvalid_reg;
    assign frame_kind     = kind_reg;
    assign frame_opcode   = opcode_reg;
    assign final_fragment = fin_reg;
    assign last_of_frame  = last_reg;
    assign closing        = closing_reg;

    a_data_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_valid |-> !frame_kind[1])
        else $error("payload byte on close or error result");
    a_close_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_frame && frame_kind[1] |-> closing)
        else $error("closing flag not set by close result");
    a_closing_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(closing_reg))
        else $error("closing flag cleared");

endmodule

[rtl/websocket_frame_deframer.sv]
// channel   | valid      | stall       | payload
// ----------+------------+-------------+----------------------------------------------
// request   | in_valid   | in_stall    | rx_byte
// result    | out_valid  | out_stall   | data_byte data_valid frame_kind frame_opcode
//           |            |             | final_fragment last_of_frame closing
//
// one received byte is taken per cycle while in_stall is low, and is parsed in that same cycle
// a result passes from the parser into the queue, then from the queue into the output register
// reset clears parser state, queue and the sticky closing flag at once; no clearing pass
// in_stall rises only when the QUEUE_DEPTH-entry queue is full, so out_stall reaches the
// input after the queue fills; bytes that give no result still need a free queue slot
module websocket_frame_deframer #(
    parameter int QUEUE_DEPTH = wdf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       in_valid,
    output logic       in_stall,
    output logic [7:0] data_byte,
    output logic       data_valid,
    output logic [1:0] frame_kind,
    output logic [3:0] frame_opcode,
    output logic       final_fragment,
    output logic       last_of_frame,
    output logic       closing,
    output logic       out_valid,
    input  logic       out_stall
);
    import wdf_pkg::*;

    logic queue_full;
    logic queue_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    // header parser and payload classifier
    wdf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // classified results waiting for the output stage
    wdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (queue_empty)
    );

    // unmasking, closing flag and result register
    wdf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .empty          (queue_empty),
        .pop_cmd        (pop_cmd),
        .pop            (pop),
        .data_byte      (data_byte),
        .data_valid     (data_valid),
        .frame_kind     (frame_kind),
        .frame_opcode   (frame_opcode),
        .final_fragment (final_fragment),
        .last_of_frame  (last_of_frame),
        .closing        (closing),
        .out_valid      (out_valid),
        .out_stall      (out_stall)
    );

endmodule

[tb/sv/deframer_checker.sv]
module deframer_checker
    import wdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       data_valid,
    input  logic [1:0] frame_kind,
    input  logic [3:0] frame_opcode,
    input  logic       final_fragment,
    input  logic       last_of_frame,
    input  logic       closing,
    input  logic       out_valid,
    input  logic       out_stall,
    output int         mismatch_count,
    output int         results_owed
);

    // data opcodes that the package does not name
    localparam logic [3:0] OP_CONTINUATION = 4'h0;
    localparam logic [3:0] OP_TEXT         = 4'h1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic [1:0] kind;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
        logic       closing;
    } frame_result_t;

    // parser state as seen by the predictor
    phase_t        parse_phase;
    logic [2:0]    header_bytes_left;
    logic [63:0]   length_left;
    logic [31:0]   key_word;
    logic [1:0]    key_index;
    logic          fin_seen;
    logic [3:0]    opcode_seen;
    logic          masked_seen;
    logic          closing_seen;

    frame_result_t predicted_results[$];
    frame_result_t oldest;
    int            faults;

    function automatic logic [1:0] classify_opcode(input logic [3:0] op);
        logic [1:0] k;
        case (op)
            OP_CONTINUATION, OP_TEXT, OP_BINARY, OP_PONG: k = KIND_DATA;
            OP_PING:                                      k = KIND_PING;
            OP_CLOSE:                                     k = KIND_CLOSE;
            default:                                      k = KIND_ERROR;
        endcase
        return k;
    endfunction

    // queue one result; a close or error frame end sets the sticky flag first
    function automatic void predict_result(input logic [7:0] value, input logic valid,
                                           input logic last);
        logic [1:0] k;
        k = classify_opcode(opcode_seen);
        if (last && k >= KIND_CLOSE)
            closing_seen = 1'b1;
        predicted_results.push_back('{value, valid, k, opcode_seen, fin_seen, last,
                                      closing_seen});
    endfunction

    // header complete: empty frame ends here, otherwise payload follows
    function automatic void finish_header();
        key_index = 2'd0;
        if (length_left == 64'd0)
        begin
            parse_phase = PH_HDR0;
            predict_result(8'h00, 1'b0, 1'b1);
        end
        else
            parse_phase = PH_PAY;
    endfunction

    function automatic void parse_rx_byte(input logic [7:0] b);
        logic [6:0] len7;
        logic [7:0] plain;
        logic [7:0] key_byte;
        logic [1:0] k;
        logic       last;
        case (parse_phase)
            PH_HDR1:
            begin
                masked_seen = b[7];
                len7        = b[6:0];
                key_word    = 32'd0;
                length_left = 64'd0;
                if (len7 == LEN_EXT16)
                begin
                    header_bytes_left = EXT16_LAST;
                    parse_phase       = PH_EXT;
                end
                else if (len7 == LEN_EXT64)
                begin
                    header_bytes_left = EXT64_LAST;
                    parse_phase       = PH_EXT;
                end
                else
                begin
                    length_left = 64'(len7);
                    if (masked_seen)
                    begin
                        header_bytes_left = KEY_LAST;
                        parse_phase       = PH_KEY;
                    end
                    else
                        finish_header();
                end
            end
            PH_EXT:
            begin
                length_left = {length_left[55:0], b};
                if (header_bytes_left != 3'd0)
                    header_bytes_left = header_bytes_left - 3'd1;
                else if (masked_seen)
                begin
                    header_bytes_left = KEY_LAST;
                    parse_phase       = PH_KEY;
                end
                else
                    finish_header();
            end
            PH_KEY:
            begin
                key_word = {key_word[23:0], b};
                if (header_bytes_left != 3'd0)
                    header_bytes_left = header_bytes_left - 3'd1;
                else
                    finish_header();
            end
            PH_PAY:
            begin
                k        = classify_opcode(opcode_seen);
                key_byte = 8'(key_word >> (8 * (3 - int'(key_index))));
                plain    = masked_seen ? (b ^ key_byte) : b;
                key_index   = key_index + 2'd1;
                length_left = length_left - 64'd1;
                last        = (length_left == 64'd0);
                if (last)
                    parse_phase = PH_HDR0;
                // pong payload is dropped; close and errors report only at frame end
                if (opcode_seen == OP_PONG)
                    ;
                else if (k >= KIND_CLOSE)
                begin
                    if (last)
                        predict_result(8'h00, 1'b0, 1'b1);
                end
                else
                    predict_result(plain, 1'b1, last);
            end
            default:
            begin
                fin_seen          = b[7];
                opcode_seen       = b[3:0];
                header_bytes_left = 3'd0;
                parse_phase       = PH_HDR1;
            end
        endcase
    endfunction

    function automatic int field_differs(input string field, input logic [7:0] want,
                                         input logic [7:0] got);
        if (want == got)
            return 0;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        return 1;
    endfunction

    // predict on each accepted byte, compare each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase       = PH_HDR0;
            header_bytes_left = 3'd0;
            length_left       = 64'd0;
            key_word          = 32'd0;
            key_index         = 2'd0;
            fin_seen          = 1'b0;
            opcode_seen       = 4'd0;
            masked_seen       = 1'b0;
            closing_seen      = 1'b0;
            predicted_results.delete();
            faults = 0;
            mismatch_count <= 0;
            results_owed   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                parse_rx_byte(rx_byte);
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual data_byte %0h kind %0d",
                             $time, data_byte, frame_kind);
                    faults++;
                end
                else
                begin
                    oldest = predicted_results.pop_front();
                    faults += field_differs("data_byte", oldest.data_byte, data_byte);
                    faults += field_differs("data_valid", 8'(oldest.data_valid), 8'(data_valid));
                    faults += field_differs("frame_kind", 8'(oldest.kind), 8'(frame_kind));
                    faults += field_differs("frame_opcode", 8'(oldest.opcode), 8'(frame_opcode));
                    faults += field_differs("final_fragment", 8'(oldest.fin),
                                            8'(final_fragment));
                    faults += field_differs("last_of_frame", 8'(oldest.last), 8'(last_of_frame));
                    faults += field_differs("closing", 8'(oldest.closing), 8'(closing));
                end
            end
            mismatch_count <= faults;
            results_owed   <= predicted_results.size();
        end
    end

endmodule

[tb/sv/tb_websocket_frame_deframer.sv]
module tb_websocket_frame_deframer;
    import wdf_pkg::*;

    localparam logic [3:0] OP_CONTINUATION = 4'h0;
    localparam logic [3:0] OP_TEXT         = 4'h1;
    localparam logic [3:0] OP_UNKNOWN      = 4'h3;

    // how the payload length is encoded
    localparam int FORM_SHORT = 0;
    localparam int FORM_EXT16 = 1;
    localparam int FORM_EXT64 = 2;

    localparam int RANDOM_BYTES = 1400;
    localparam int HOLD_CYCLES  = 200;

    logic       clk;
    logic       rst_n;
    logic [7:0] rx_byte;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       data_valid;
    logic [1:0] frame_kind;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       last_of_frame;
    logic       closing;
    logic       out_valid;
    logic       out_stall;

    int mismatch_count;
    int results_owed;
    int bytes_sent;
    bit sender_idles;
    bit receiver_idles;
    bit hold_output;

    websocket_frame_deframer DUT (.*);

    deframer_checker monitor (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("websocket_frame_deframer regression: fail");
        $finish;
    end

    // offer one byte, after a random gap while the sender idles, and wait until it is taken
    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = sender_idles ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // stop offering and wait until every predicted result has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
    endtask

    task automatic send_frame(input logic [7:0] head, input logic masked, input int form,
                              input logic [63:0] length, input int payload_count);
        logic [31:0] key;
        key = $urandom;
        send_byte(head);
        case (form)
            FORM_EXT16:
            begin
                send_byte({masked, LEN_EXT16});
                send_byte(length[15:8]);
                send_byte(length[7:0]);
            end
            FORM_EXT64:
            begin
                send_byte({masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(length[8 * i +: 8]);
            end
            default:
                send_byte({masked, length[6:0]});
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--)
                send_byte(key[8 * i +: 8]);
        repeat (payload_count) send_byte(8'($urandom));
    endtask

    // well-formed frame with random opcode, mask, length form and content
    task automatic send_random_frame();
        logic [3:0]  op;
        logic [7:0]  head;
        logic        masked;
        logic [63:0] length;
        int          pick;
        int          form;
        pick = $urandom_range(0, 15);
        if (pick < 7)
            op = 4'($urandom_range(int'(OP_CONTINUATION), int'(OP_BINARY)));
        else if (pick < 9)
            op = OP_PING;
        else if (pick < 11)
            op = OP_PONG;
        else if (pick == 11)
            op = OP_CLOSE;
        else if (pick == 12)
            op = 4'($urandom_range(int'(OP_BINARY) + 1, int'(OP_CLOSE) - 1));
        else if (pick == 13)
            op = 4'($urandom_range(int'(OP_PONG) + 1, 15));
        else
            op = OP_TEXT;
        head = {1'($urandom), 3'($urandom), op};
        // occasionally a fully random first header byte
        if ($urandom_range(0, 9) == 0)
            head = 8'($urandom);
        masked = 1'($urandom);
        form   = FORM_SHORT;
        pick   = $urandom_range(0, 9);
        if (pick == 0)
            length = 64'd0;
        else if (pick <= 6)
            length = 64'($urandom_range(1, 20));
        else if (pick == 7)
            length = 64'($urandom_range(100, 125));
        else if (pick == 8)
        begin
            form   = FORM_EXT16;
            length = 64'($urandom_range(0, 300));
        end
        else
        begin
            form   = FORM_EXT64;
            length = 64'($urandom_range(0, 40));
        end
        send_frame(head, masked, form, length, int'(length));
    endtask

    // receiver: random stalls per result, one long hold-off on request
    initial
    begin
        int stall_cycles;
        out_stall <= 1'b0;
        receiver_idles = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                receiver_idles = !receiver_idles;
            stall_cycles = receiver_idles ? $urandom_range(0, 19) : 0;
            if (hold_output)
            begin
                hold_output  = 1'b0;
                stall_cycles = HOLD_CYCLES;
            end
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [63:0] huge_length;
        bit          hold_done;
        bit          pause_done;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        rx_byte  <= 8'h00;
        sender_idles = 1'b0;
        hold_output  = 1'b0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        bytes_sent   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-length text frame
        send_frame({1'b1, 3'b000, OP_TEXT}, 1'b0, FORM_SHORT, 64'd0, 0);
        // masked ping echoed byte by byte
        send_frame({1'b1, 3'b000, OP_PING}, 1'b1, FORM_SHORT, 64'd2, 2);
        // zero-length pong gives one empty result
        send_frame({1'b0, 3'b000, OP_PONG}, 1'b0, FORM_SHORT, 64'd0, 0);
        // pong payload is dropped
        send_frame({1'b1, 3'b000, OP_PONG}, 1'b0, FORM_SHORT, 64'd1, 1);
        // close with payload reports at frame end and sets the closing flag
        send_frame({1'b1, 3'b000, OP_CLOSE}, 1'b0, FORM_SHORT, 64'd1, 1);
        // unknown opcode with reserved bits set, empty frame
        send_frame({1'b1, 3'b111, OP_UNKNOWN}, 1'b0, FORM_SHORT, 64'd0, 0);
        wait_drained();

        sender_idles = 1'b1;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 7) == 0)
                sender_idles = !sender_idles;
            // long output hold-off while bytes keep coming
            if (!hold_done && bytes_sent > 500)
            begin
                hold_done    = 1'b1;
                hold_output  = 1'b1;
                sender_idles = 1'b0;
            end
            // sender pause until the pipeline is empty
            if (!pause_done && bytes_sent > 900)
            begin
                pause_done = 1'b1;
                wait_drained();
            end
            send_random_frame();
        end

        // huge 64-bit length: counted down, never finished within the run
        huge_length = {1'b1, 31'($urandom), 32'($urandom)};
        send_frame({1'b0, 3'b000, OP_BINARY}, 1'b1, FORM_EXT64, huge_length, 16);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("websocket_frame_deframer regression: pass");
        else
            $display("websocket_frame_deframer regression: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/wdf_pkg.sv
rtl/wdf_front.sv
rtl/wdf_queue.sv
rtl/wdf_back.sv
rtl/websocket_frame_deframer.sv
tb/sv/deframer_checker.sv
tb/sv/tb_websocket_frame_deframer.sv
